// File: design/aeps_pkg.sv
// Shared types and constants of the adaptive entry port select block.
// No dependencies; used by the lane, merge and top level modules.
`timescale 1ns / 1ps

package aeps_pkg;

  localparam int unsigned ENTRIES   = 4;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned SCORE_W   = 17;
  localparam int unsigned WGT_W     = 20;
  localparam int unsigned SUM_W     = 23;
  localparam int unsigned PROD_W    = 39;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam logic [SCORE_W-1:0] EPS_FIX = 17'd26;

  localparam logic [CFG_IDX_W-1:0] REG_MESH_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONG_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CREDITS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 2'd3;

  localparam logic MODE_MIN_SCORE = 1'b0;

  typedef struct packed {
    logic [4:0]  mesh_size;
    logic [15:0] congestion_weight;
    logic [7:0]  max_credits;
    logic        select_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         hops;
    logic [SCORE_W-1:0] score;
    logic [WGT_W-1:0]   weight;
  } lane_res_t;

  typedef struct packed {
    logic [IDX_W-1:0] chosen_entry;
    logic [IDX_W-1:0] nearest_entry;
    logic             tie_seen;
    logic             rerouted;
    logic [31:0]      chosen_total;
    logic [31:0]      reroute_total;
  } result_t;

endpackage

// File: design/aeps_lane.sv
// One candidate lane: distance, score and inverse-score weight of one entry.
// Reuses its own bit-serial restoring divider for every division; depends on aeps_pkg.
`timescale 1ns / 1ps

module aeps_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  aeps_pkg::cfg_t      cfg_i,
  input  logic [7:0]          dest_i,
  input  logic [7:0]          router_i,
  input  logic [7:0]          credits_i,
  output logic                done_o,
  output aeps_pkg::lane_res_t res_o
);

  typedef enum logic [2:0] {
    L_IDLE, L_RMOD, L_RDIV, L_DMOD, L_DDIV, L_CONG, L_WGT
  } lane_st_e;

  lane_st_e                       st_q;
  logic [24:0]                    dq_q;
  logic [aeps_pkg::SCORE_W-1:0]   rem_q;
  logic [4:0]                     cnt_q;
  logic [7:0]                     rrow_q, rcol_q;
  logic [7:0]                     dist_q;
  logic [aeps_pkg::SCORE_W-1:0]   score_q;
  logic [aeps_pkg::WGT_W-1:0]     wgt_q;
  logic                           done_q;

  logic [4:0]                     m;
  logic [9:0]                     n;
  logic [7:0]                     mc, csat, diff;
  logic [23:0]                    prod;
  logic [aeps_pkg::SCORE_W-1:0]   divisor;
  logic [aeps_pkg::SCORE_W:0]     t;
  logic                           ge;
  logic [aeps_pkg::SCORE_W-1:0]   rem_nx;
  logic [24:0]                    dq_nx;
  logic                           last;
  logic [7:0]                     rd, cd;
  logic [8:0]                     dsum;
  logic [aeps_pkg::SCORE_W-1:0]   score_nx;

  always_comb begin
    m    = (cfg_i.mesh_size == 5'd0) ? 5'd1 : cfg_i.mesh_size;
    n    = 10'(m * m);
    mc   = (cfg_i.max_credits == 8'd0) ? 8'd1 : cfg_i.max_credits;
    csat = (credits_i > mc) ? mc : credits_i;
    diff = mc - csat;
    prod = 24'(cfg_i.congestion_weight * diff);
    case (st_q)
      L_RMOD, L_DMOD: divisor = 17'(n);
      L_RDIV, L_DDIV: divisor = 17'(m);
      L_CONG:         divisor = 17'(mc);
      L_WGT:          divisor = score_q + aeps_pkg::EPS_FIX;
      default:        divisor = 17'd1;
    endcase
    t      = {rem_q, dq_q[24]};
    ge     = t >= {1'b0, divisor};
    rem_nx = ge ? 17'(t - {1'b0, divisor}) : t[aeps_pkg::SCORE_W-1:0];
    dq_nx  = {dq_q[23:0], ge};
    last   = cnt_q == 5'd1;
    rd     = (rrow_q > dq_nx[7:0]) ? rrow_q - dq_nx[7:0] : dq_nx[7:0] - rrow_q;
    cd     = (rcol_q > rem_nx[7:0]) ? rcol_q - rem_nx[7:0] : rem_nx[7:0] - rcol_q;
    dsum   = {1'b0, rd} + {1'b0, cd};
    score_nx = {1'b0, dist_q, 8'd0} + {1'b0, dq_nx[15:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= L_IDLE;
      cnt_q  <= 5'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (st_q == L_IDLE) begin
        if (start_i) begin
          dq_q  <= {router_i, 17'd0};
          rem_q <= '0;
          cnt_q <= 5'd8;
          st_q  <= L_RMOD;
        end
      end else begin
        dq_q  <= dq_nx;
        rem_q <= rem_nx;
        cnt_q <= cnt_q - 5'd1;
        if (last) begin
          rem_q <= '0;
          case (st_q)
            L_RMOD: begin
              dq_q  <= {rem_nx[7:0], 17'd0};
              cnt_q <= 5'd8;
              st_q  <= L_RDIV;
            end
            L_RDIV: begin
              rrow_q <= dq_nx[7:0];
              rcol_q <= rem_nx[7:0];
              dq_q   <= {dest_i, 17'd0};
              cnt_q  <= 5'd8;
              st_q   <= L_DMOD;
            end
            L_DMOD: begin
              dq_q  <= {rem_nx[7:0], 17'd0};
              cnt_q <= 5'd8;
              st_q  <= L_DDIV;
            end
            L_DDIV: begin
              dist_q <= dsum[7:0];
              dq_q   <= {prod, 1'b0};
              cnt_q  <= 5'd24;
              st_q   <= L_CONG;
            end
            L_CONG: begin
              score_q <= score_nx;
              dq_q    <= {1'b1, 24'd0};
              cnt_q   <= 5'd25;
              st_q    <= L_WGT;
            end
            L_WGT: begin
              wgt_q  <= dq_nx[aeps_pkg::WGT_W-1:0];
              done_q <= 1'b1;
              st_q   <= L_IDLE;
            end
            default: st_q <= L_IDLE;
          endcase
        end
      end
    end
  end

  assign done_o       = done_q;
  assign res_o.hops   = dist_q;
  assign res_o.score  = score_q;
  assign res_o.weight = wgt_q;

endmodule

// File: design/aeps_merge.sv
// Merge stage: nearest entry, min-score or weighted random choice, counters.
// Three registered steps; depends on aeps_pkg.
`timescale 1ns / 1ps

module aeps_merge #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                mode_i,
  input  logic [15:0]         rand_i,
  input  aeps_pkg::lane_res_t lane_i [aeps_pkg::ENTRIES],
  output logic                done_o,
  output aeps_pkg::result_t   res_o
);

  localparam int unsigned N = aeps_pkg::ENTRIES;
  localparam int unsigned W = aeps_pkg::IDX_W;

  logic                          v1_q, v2_q, v3_q;
  logic [aeps_pkg::PROD_W-1:0]   prod_q;
  logic [aeps_pkg::SUM_W-1:0]    acc_q   [N];
  logic [aeps_pkg::SCORE_W-1:0]  score_q [N];
  logic [7:0]                    dist_q  [N];
  logic                          mode_q;
  logic [W-1:0]                  tie_ptr_q;
  logic [W-1:0]                  ch_q, near_q;
  logic                          tie_q;
  logic [COUNT_BITS-1:0]         cnt_q [N];
  logic [COUNT_BITS-1:0]         rr_q;
  aeps_pkg::result_t             res_q;

  logic [aeps_pkg::SUM_W-1:0]    acc_d [N];
  logic [aeps_pkg::SUM_W-1:0]    run;
  logic [W-1:0]                  near_d, min_d, rnd_d, k;
  logic [aeps_pkg::SCORE_W-1:0]  best;
  logic                          tie_d;
  logic [COUNT_BITS-1:0]         cnt_nx, rr_nx;
  logic                          rer;

  always_comb begin
    run = '0;
    for (int i = 0; i < N; i++) begin
      run      = run + 23'(lane_i[i].weight);
      acc_d[i] = run;
    end
    near_d = '0;
    for (int i = 1; i < N; i++) begin
      if (dist_q[i] < dist_q[near_d]) near_d = W'(i);
    end
    min_d = tie_ptr_q;
    best  = score_q[tie_ptr_q];
    tie_d = 1'b0;
    for (int j = 1; j < N; j++) begin
      k = tie_ptr_q + W'(j);
      if (score_q[k] < best) begin
        best  = score_q[k];
        min_d = k;
        tie_d = 1'b0;
      end else if (score_q[k] == best) begin
        tie_d = 1'b1;
      end
    end
    rnd_d = W'(N - 1);
    for (int i = N - 1; i >= 0; i--) begin
      if (prod_q <= {acc_q[i], 16'd0}) rnd_d = W'(i);
    end
    rer    = ch_q != near_q;
    cnt_nx = cnt_q[ch_q] + COUNT_BITS'(1);
    rr_nx  = rer ? rr_q + COUNT_BITS'(1) : rr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      tie_ptr_q <= '0;
      rr_q      <= '0;
      for (int i = 0; i < N; i++) cnt_q[i] <= '0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (start_i) begin
        prod_q <= 39'(rand_i * acc_d[N-1]);
        mode_q <= mode_i;
        for (int i = 0; i < N; i++) begin
          acc_q[i]   <= acc_d[i];
          score_q[i] <= lane_i[i].score;
          dist_q[i]  <= lane_i[i].hops;
        end
      end
      if (v1_q) begin
        near_q <= near_d;
        if (mode_q == aeps_pkg::MODE_MIN_SCORE) begin
          ch_q  <= min_d;
          tie_q <= tie_d;
          if (tie_d) tie_ptr_q <= min_d + W'(1);
        end else begin
          ch_q  <= rnd_d;
          tie_q <= 1'b0;
        end
      end
      if (v2_q) begin
        cnt_q[ch_q]         <= cnt_nx;
        rr_q                <= rr_nx;
        res_q.chosen_entry  <= ch_q;
        res_q.nearest_entry <= near_q;
        res_q.tie_seen      <= tie_q;
        res_q.rerouted      <= rer;
        res_q.chosen_total  <= 32'(cnt_nx);
        res_q.reroute_total <= 32'(rr_nx);
      end
    end
  end

  assign done_o = v3_q;
  assign res_o  = res_q;

endmodule

// File: design/adaptive_entry_port_select_core.sv
// Top level of the adaptive entry port select block: ports, configuration
// registers, item holding register, four aeps_lane units and aeps_merge.
//
//   channel | valid     | stall       | payload
//   input   | in_valid_i| in_stall_o  | dest_router_i .. entry3_credits_i
//   output  | out_valid_o| out_stall_i| chosen_entry_o .. reroute_total_o
//   config  | cfg_we_i  | (none)      | cfg_idx_i, cfg_data_i
//
// An item goes from acceptance to out_valid_o through these steps: start the lanes,
// the lane divider (mesh divisions, congestion term, weight), see the lanes done,
// start the merge, the merge steps, load the output.
// Reset restores the register defaults and clears pointer and counters.
// A result waiting under out_stall_i holds the next item before the merge;
// in_stall_o stays high until the result is loaded, so no new item is taken before then.
`timescale 1ns / 1ps

module adaptive_entry_port_select_core #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  dest_router_i,
  input  logic [15:0] rand_fraction_i,
  input  logic [7:0]  entry0_router_i,
  input  logic [7:0]  entry1_router_i,
  input  logic [7:0]  entry2_router_i,
  input  logic [7:0]  entry3_router_i,
  input  logic [7:0]  entry0_credits_i,
  input  logic [7:0]  entry1_credits_i,
  input  logic [7:0]  entry2_credits_i,
  input  logic [7:0]  entry3_credits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  chosen_entry_o,
  output logic [1:0]  nearest_entry_o,
  output logic        tie_seen_o,
  output logic        rerouted_o,
  output logic [31:0] chosen_total_o,
  output logic [31:0] reroute_total_o
);

  localparam int unsigned N = aeps_pkg::ENTRIES;

  typedef enum logic [1:0] {T_IDLE, T_LANES, T_WAIT, T_MERGE} top_st_e;

  top_st_e             st_q;
  aeps_pkg::cfg_t      cfg_q;
  logic                start_q;
  logic [7:0]          dest_q;
  logic [15:0]         rand_q;
  logic [7:0]          rtr_q [N];
  logic [7:0]          crd_q [N];
  logic                mstart_q;
  logic                out_valid_q;
  aeps_pkg::result_t   out_q;

  logic                accept;
  logic [N-1:0]        lane_done;
  aeps_pkg::lane_res_t lane_res [N];
  logic                merge_done;
  aeps_pkg::result_t   merge_res;

  assign in_stall_o = st_q != T_IDLE;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mesh_size         <= 5'd4;
      cfg_q.congestion_weight <= 16'd256;
      cfg_q.max_credits       <= 8'd4;
      cfg_q.select_mode       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aeps_pkg::REG_MESH_SIZE:   cfg_q.mesh_size         <= cfg_data_i[4:0];
        aeps_pkg::REG_CONG_WEIGHT: cfg_q.congestion_weight <= cfg_data_i;
        aeps_pkg::REG_MAX_CREDITS: cfg_q.max_credits       <= cfg_data_i[7:0];
        aeps_pkg::REG_SELECT_MODE: cfg_q.select_mode       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= T_IDLE;
      start_q     <= 1'b0;
      mstart_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q  <= 1'b0;
      mstart_q <= 1'b0;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (st_q)
        T_IDLE: begin
          if (accept) begin
            dest_q   <= dest_router_i;
            rand_q   <= rand_fraction_i;
            rtr_q[0] <= entry0_router_i;
            rtr_q[1] <= entry1_router_i;
            rtr_q[2] <= entry2_router_i;
            rtr_q[3] <= entry3_router_i;
            crd_q[0] <= entry0_credits_i;
            crd_q[1] <= entry1_credits_i;
            crd_q[2] <= entry2_credits_i;
            crd_q[3] <= entry3_credits_i;
            start_q  <= 1'b1;
            st_q     <= T_LANES;
          end
        end
        T_LANES: begin
          if (&lane_done) st_q <= T_WAIT;
        end
        T_WAIT: begin
          if (!out_valid_q) begin
            mstart_q <= 1'b1;
            st_q     <= T_MERGE;
          end
        end
        T_MERGE: begin
          if (merge_done) begin
            out_q       <= merge_res;
            out_valid_q <= 1'b1;
            st_q        <= T_IDLE;
          end
        end
        default: st_q <= T_IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_lane
    aeps_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   (start_q),
      .cfg_i     (cfg_q),
      .dest_i    (dest_q),
      .router_i  (rtr_q[g]),
      .credits_i (crd_q[g]),
      .done_o    (lane_done[g]),
      .res_o     (lane_res[g])
    );
  end

  aeps_merge #(
    .COUNT_BITS (COUNT_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart_q),
    .mode_i  (cfg_q.select_mode),
    .rand_i  (rand_q),
    .lane_i  (lane_res),
    .done_o  (merge_done),
    .res_o   (merge_res)
  );

  assign out_valid_o     = out_valid_q;
  assign chosen_entry_o  = out_q.chosen_entry;
  assign nearest_entry_o = out_q.nearest_entry;
  assign tie_seen_o      = out_q.tie_seen;
  assign rerouted_o      = out_q.rerouted;
  assign chosen_total_o  = out_q.chosen_total;
  assign reroute_total_o = out_q.reroute_total;

endmodule

// File: verif/aeps_checker.sv
// Checker for adaptive_entry_port_select_core: follows config writes, predicts each result
// from accepted input transactions, and compares the output transactions in order.
// Depends on aeps_pkg for the result and register index definitions.
`timescale 1ns / 1ps

module aeps_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [7:0]        dest_router_i,
  input  logic [15:0]       rand_fraction_i,
  input  logic [7:0]        entry_router_i [aeps_pkg::ENTRIES],
  input  logic [7:0]        entry_credits_i [aeps_pkg::ENTRIES],
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  aeps_pkg::result_t result_i,
  output int                errors_o,
  output int                pending_o
);

  localparam int unsigned N = aeps_pkg::ENTRIES;

  logic [4:0]        mesh_q;
  logic [15:0]       weight_q;
  logic [7:0]        cap_q;
  logic              mode_q;
  logic [1:0]        tie_ptr_q;
  logic [31:0]       choice_cnt_q [N];
  logic [31:0]       reroute_cnt_q;
  aeps_pkg::result_t expected_q [$];

  function automatic int unsigned mesh_distance(int unsigned a, int unsigned b,
                                                int unsigned m);
    int unsigned n, s, d, rd, cd;
    n = m * m;
    s = a % n;
    d = b % n;
    rd = (s / m > d / m) ? s / m - d / m : d / m - s / m;
    cd = (s % m > d % m) ? s % m - d % m : d % m - s % m;
    return rd + cd;
  endfunction

  function automatic aeps_pkg::result_t select_entry();
    int unsigned m, mc, c, best, start, k, chosen, nearest;
    int unsigned hops [N];
    int unsigned score [N];
    longint unsigned w [N], sum, acc;
    bit tied;
    aeps_pkg::result_t r;
    m = (mesh_q == 0) ? 1 : mesh_q;
    mc = (cap_q == 0) ? 1 : cap_q;
    tied = 0;
    for (int i = 0; i < N; i++) begin
      c = (entry_credits_i[i] > mc) ? mc : entry_credits_i[i];
      hops[i] = mesh_distance(entry_router_i[i], dest_router_i, m);
      score[i] = hops[i] * 256 + (weight_q * (mc - c)) / mc;
    end
    nearest = 0;
    for (int i = 1; i < N; i++) begin
      if (hops[i] < hops[nearest]) nearest = i;
    end
    if (mode_q == aeps_pkg::MODE_MIN_SCORE) begin
      start = tie_ptr_q;
      best = score[start];
      chosen = start;
      for (int j = 1; j < N; j++) begin
        k = (start + j) % N;
        if (score[k] < best) begin
          best = score[k];
          chosen = k;
          tied = 0;
        end else if (score[k] == best) begin
          tied = 1;
        end
      end
      if (tied) tie_ptr_q = 2'((chosen + 1) % N);
    end else begin
      sum = 0;
      acc = 0;
      for (int i = 0; i < N; i++) begin
        w[i] = (64'd1 << 24) / (score[i] + aeps_pkg::EPS_FIX);
        sum += w[i];
      end
      chosen = N - 1;
      for (int i = 0; i < N; i++) begin
        acc += w[i];
        if (rand_fraction_i * sum <= (acc << 16)) begin
          chosen = i;
          break;
        end
      end
    end
    choice_cnt_q[chosen] = choice_cnt_q[chosen] + 32'd1;
    if (chosen != nearest) reroute_cnt_q = reroute_cnt_q + 32'd1;
    r.chosen_entry = 2'(chosen);
    r.nearest_entry = 2'(nearest);
    r.tie_seen = tied;
    r.rerouted = (chosen != nearest);
    r.chosen_total = choice_cnt_q[chosen];
    r.reroute_total = reroute_cnt_q;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    aeps_pkg::result_t e;
    if (!rst_ni) begin
      mesh_q = 5'd4;
      weight_q = 16'd256;
      cap_q = 8'd4;
      mode_q = aeps_pkg::MODE_MIN_SCORE;
      tie_ptr_q = '0;
      for (int i = 0; i < N; i++) choice_cnt_q[i] = '0;
      reroute_cnt_q = '0;
      expected_q.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none actual %0h", $time, result_i);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          check_field("chosen_entry", 32'(e.chosen_entry), 32'(result_i.chosen_entry));
          check_field("nearest_entry", 32'(e.nearest_entry), 32'(result_i.nearest_entry));
          check_field("tie_seen", 32'(e.tie_seen), 32'(result_i.tie_seen));
          check_field("rerouted", 32'(e.rerouted), 32'(result_i.rerouted));
          check_field("chosen_total", e.chosen_total, result_i.chosen_total);
          check_field("reroute_total", e.reroute_total, result_i.reroute_total);
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(select_entry());
      if (cfg_we_i) begin
        case (cfg_idx_i)
          aeps_pkg::REG_MESH_SIZE:   mesh_q = cfg_data_i[4:0];
          aeps_pkg::REG_CONG_WEIGHT: weight_q = cfg_data_i;
          aeps_pkg::REG_MAX_CREDITS: cap_q = cfg_data_i[7:0];
          aeps_pkg::REG_SELECT_MODE: mode_q = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// File: verif/adaptive_entry_port_select_core_tb.sv
// Testbench top for adaptive_entry_port_select_core: clock, reset, config phases and
// randomized request transactions with idle and stall gaps; verdict from aeps_checker.
// Depends on aeps_pkg, the block and verif/aeps_checker.sv.
`timescale 1ns / 1ps

module adaptive_entry_port_select_core_tb;

  localparam int unsigned N = aeps_pkg::ENTRIES;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = '0;
  logic [15:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        dest_q = '0;
  logic [15:0]       frac_q = '0;
  logic [7:0]        router_q [N] = '{default: '0};
  logic [7:0]        credit_q [N] = '{default: '0};
  logic              out_valid;
  logic              out_stall = 1'b1;
  aeps_pkg::result_t result;
  int                errors, pending;
  int                gap_max, stall_max, stall_left;
  logic [4:0]        mesh_cfg;
  logic [7:0]        cap_cfg;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  adaptive_entry_port_select_core DUT (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .dest_router_i(dest_q), .rand_fraction_i(frac_q),
    .entry0_router_i(router_q[0]), .entry1_router_i(router_q[1]),
    .entry2_router_i(router_q[2]), .entry3_router_i(router_q[3]),
    .entry0_credits_i(credit_q[0]), .entry1_credits_i(credit_q[1]),
    .entry2_credits_i(credit_q[2]), .entry3_credits_i(credit_q[3]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .chosen_entry_o(result.chosen_entry), .nearest_entry_o(result.nearest_entry),
    .tie_seen_o(result.tie_seen), .rerouted_o(result.rerouted),
    .chosen_total_o(result.chosen_total), .reroute_total_o(result.reroute_total)
  );

  aeps_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .dest_router_i(dest_q), .rand_fraction_i(frac_q),
    .entry_router_i(router_q), .entry_credits_i(credit_q),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .result_i(result),
    .errors_o(errors), .pending_o(pending)
  );

  // hold stall for a random count after each output transaction
  always @(posedge clk_i) begin
    int n;
    n = stall_left;
    if (out_valid && !out_stall) n = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
    else if (n > 0) n--;
    stall_left <= n;
    out_stall <= (n > 0);
  end

  task automatic send_request(logic [7:0] dest, logic [15:0] frac,
                              logic [7:0] r0, logic [7:0] r1, logic [7:0] r2, logic [7:0] r3,
                              logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic [7:0] c3);
    int gap;
    bit acc;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    dest_q <= dest;
    frac_q <= frac;
    router_q <= '{r0, r1, r2, r3};
    credit_q <= '{c0, c1, c2, c3};
    forever begin
      @(negedge clk_i);
      acc = !in_stall;
      @(posedge clk_i);
      if (acc) break;
    end
  endtask

  task automatic send_random();
    logic [7:0] d, shared;
    logic [7:0] r [N];
    logic [7:0] c [N];
    int kind;
    d = 8'($urandom_range(0, 255));
    kind = $urandom_range(0, 3);
    shared = 8'($urandom_range(0, 255));
    for (int i = 0; i < N; i++) begin
      case (kind)
        0: begin
          r[i] = 8'($urandom_range(0, 255));
          c[i] = 8'($urandom_range(0, 255));
        end
        1: begin
          r[i] = ($urandom_range(0, 1) == 0) ? d : 8'(d + mesh_cfg * $urandom_range(0, 1));
          c[i] = shared;
        end
        default: begin
          r[i] = 8'(d + $urandom_range(0, 3) - 1);
          c[i] = 8'($urandom_range(0, cap_cfg + 2));
        end
      endcase
    end
    send_request(d, 16'($urandom_range(0, 65535)), r[0], r[1], r[2], r[3],
                 c[0], c[1], c[2], c[3]);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] cfg_tbl [6][4];
    logic [15:0] v [4];
    cfg_tbl = '{'{1, 0, 1, 0}, '{16, 65535, 255, 1}, '{31, 65535, 0, 0},
                '{0, 1234, 7, 1}, '{16, 0, 255, 0}, '{2, 65535, 1, 1}};
    gap_max = 0;
    stall_max = 0;
    stall_left = 0;
    mesh_cfg = 5'd4;
    cap_cfg = 8'd4;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    repeat (5) send_request(0, 0, 0, 0, 0, 0, 4, 4, 4, 4);
    send_request(255, 65535, 255, 255, 255, 255, 255, 255, 255, 255);
    send_request(255, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(15, 0, 0, 3, 12, 15, 4, 0, 2, 1);
    send_request(0, 0, 15, 5, 1, 0, 4, 4, 4, 0);
    send_request(170, 21845, 85, 170, 16, 31, 1, 2, 3, 4);
    send_request(5, 0, 6, 4, 9, 1, 3, 3, 3, 3);
    write_reg(aeps_pkg::REG_SELECT_MODE, 16'hFFFF);
    send_request(0, 0, 0, 5, 10, 15, 4, 0, 1, 2);
    send_request(0, 65535, 0, 5, 10, 15, 4, 0, 1, 2);
    send_request(0, 65535, 0, 0, 0, 0, 4, 4, 4, 4);
    send_request(3, 0, 12, 15, 0, 3, 0, 0, 0, 0);
    send_request(255, 32768, 0, 255, 128, 64, 255, 0, 4, 2);

    for (int p = 0; p < 10; p++) begin
      for (int k = 0; k < 4; k++) v[k] = (p < 6) ? cfg_tbl[p][k] : 16'($urandom_range(0, 65535));
      mesh_cfg = v[0][4:0];
      cap_cfg = v[2][7:0];
      write_reg(aeps_pkg::REG_MESH_SIZE, {11'($urandom_range(0, 2047)), v[0][4:0]});
      write_reg(aeps_pkg::REG_CONG_WEIGHT, v[1]);
      write_reg(aeps_pkg::REG_MAX_CREDITS, {8'($urandom_range(0, 255)), v[2][7:0]});
      write_reg(aeps_pkg::REG_SELECT_MODE, {15'($urandom_range(0, 32767)), v[3][0]});
      for (int n = 0; n < 183; n++) begin
        if (n % 60 == 0) begin
          gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
          stall_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
        end
        send_random();
      end
    end
    in_valid <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
design/aeps_pkg.sv
design/aeps_lane.sv
design/aeps_merge.sv
design/adaptive_entry_port_select_core.sv
verif/aeps_checker.sv
verif/adaptive_entry_port_select_core_tb.sv
